// File: rtl/gcd_lcm_with_overflow_defines.svh
// assertion macros shared by the gcd and lcm block
`ifndef GCD_LCM_WITH_OVERFLOW_DEFINES_SVH
`define GCD_LCM_WITH_OVERFLOW_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GLO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GLO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gcdlcm_pkg.sv
// shared constants and controller/datapath interface types
package gcdlcm_pkg;

    localparam int FIELD_W        = 63;
    localparam int S_TDATA_W      = 128;
    localparam int M_TDATA_W      = 128;
    localparam int DATA_WIDTH_DEF = 64;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic merge;
        logic shift;
        logic div_init;
        logic div_step;
        logic mul_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic k_zero;
        logic cnt_zero;
        logic zero_op;
    } sts_t;

endpackage

// File: rtl/gcdlcm_dp.sv
// datapath: binary gcd, restoring divider, overflow-checked serial multiplier
module gcdlcm_dp
    import gcdlcm_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic               clk,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [FIELD_W-1:0] operand_a,
    input  logic [FIELD_W-1:0] operand_b,
    output logic [FIELD_W-1:0] gcd_value,
    output logic [FIELD_W-1:0] lcm_value,
    output logic               overflow,
    output logic               zero_operand
);

    localparam int W  = DATA_WIDTH - 1;
    localparam int CW = $clog2(W);

    logic [W-1:0]       x_reg, x_next;
    logic [W-1:0]       y_reg, y_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [W-1:0]       big_reg;
    logic [W-1:0]       small_reg;
    logic [W-1:0]       num_reg, num_next;
    logic [W-1:0]       rem_reg, rem_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [W+1:0]       acc_reg, acc_next;
    logic               ovf_reg, ovf_next;
    logic               zero_reg;
    logic [FIELD_W-1:0] gcd_out_reg;
    logic [FIELD_W-1:0] lcm_out_reg;
    logic               ovf_out_reg;
    logic               zero_out_reg;

    logic [W-1:0] a_in, b_in;
    logic         x_ge_y;
    logic [W-1:0] diff;
    logic [W:0]   rem_sh;
    logic [W:0]   rem_sub;
    logic         q_bit;
    logic [W+1:0] mul_add;

    assign a_in = operand_a[W-1:0];
    assign b_in = operand_b[W-1:0];

    assign x_ge_y  = x_reg >= y_reg;
    assign diff    = x_ge_y ? (x_reg - y_reg) : (y_reg - x_reg);
    assign rem_sh  = {rem_reg, num_reg[W-1]};
    assign rem_sub = rem_sh - {1'b0, x_reg};
    assign q_bit   = rem_sh >= {1'b0, x_reg};
    assign mul_add = {acc_reg[W:0], 1'b0}
                   + (num_reg[W-1] ? (W+2)'(small_reg) : '0);

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        k_next   = k_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        if (cmd.load)
        begin
            x_next = a_in;
            y_next = b_in;
            k_next = '0;
        end
        if (cmd.gcd_step)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_ge_y)
            begin
                x_next = diff >> 1;
            end
            else
            begin
                y_next = diff >> 1;
            end
        end
        if (cmd.merge)
        begin
            x_next = x_reg | y_reg;
        end
        if (cmd.shift)
        begin
            x_next = x_reg << 1;
            k_next = k_reg - 1'b1;
        end
        if (cmd.div_init)
        begin
            num_next = big_reg;
            rem_next = '0;
            cnt_next = CW'(W - 1);
            acc_next = '0;
            ovf_next = 1'b0;
        end
        if (cmd.div_step)
        begin
            rem_next = q_bit ? rem_sub[W-1:0] : rem_sh[W-1:0];
            num_next = {num_reg[W-2:0], q_bit};
            cnt_next = (cnt_reg == '0) ? CW'(W - 1) : cnt_reg - 1'b1;
        end
        if (cmd.mul_step)
        begin
            num_next = {num_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (!ovf_reg)
            begin
                acc_next = mul_add;
                ovf_next = mul_add[W+1:W] != 2'b00;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        k_reg   <= k_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        ovf_reg <= ovf_next;
        if (cmd.load)
        begin
            zero_reg  <= (a_in == '0) || (b_in == '0);
            big_reg   <= (a_in > b_in) ? a_in : b_in;
            small_reg <= (a_in > b_in) ? b_in : a_in;
        end
        if (cmd.out_load)
        begin
            gcd_out_reg  <= FIELD_W'(x_reg);
            lcm_out_reg  <= (zero_reg || ovf_reg) ? '0 : FIELD_W'(acc_reg[W-1:0]);
            ovf_out_reg  <= ovf_reg && !zero_reg;
            zero_out_reg <= zero_reg;
        end
    end

    assign sts.gcd_done = (x_reg == '0) || (y_reg == '0);
    assign sts.k_zero   = k_reg == '0;
    assign sts.cnt_zero = cnt_reg == '0;
    assign sts.zero_op  = zero_reg;

    assign gcd_value    = gcd_out_reg;
    assign lcm_value    = lcm_out_reg;
    assign overflow     = ovf_out_reg;
    assign zero_operand = zero_out_reg;

endmodule

// File: rtl/gcdlcm_ctrl.sv
// controller: sequences gcd, divide, multiply and result hand-off
`include "gcd_lcm_with_overflow_defines.svh"

module gcdlcm_ctrl
    import gcdlcm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GCD    = 3'd1;
    localparam logic [2:0] ST_GSHIFT = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (sts.gcd_done)
                begin
                    cmd.merge  = 1'b1;
                    state_next = ST_GSHIFT;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_GSHIFT:
            begin
                if (!sts.k_zero)
                begin
                    cmd.shift = 1'b1;
                end
                else if (sts.zero_op)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.cnt_zero)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.cnt_zero)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;

    `GLO_ASSERT_NEXT(a_load_shows, cmd.out_load, m_tvalid, "result load not presented")
    `GLO_ASSERT_NOW(a_no_mul_zero, state_reg == ST_MUL, !sts.zero_op, "multiply on zero operand")
    `GLO_ASSERT_NEXT(a_div_to_mul, (state_reg == ST_DIV) && sts.cnt_zero,
        state_reg == ST_MUL, "divide did not hand over to multiply")

endmodule

// File: rtl/gcd_lcm_with_overflow.sv
// steps in order: binary gcd, shift-back by common factors of two, restoring divide, serial multiply
// one item at a time; the next item is taken while the result waits on m_tready
// asynchronous active-low reset clears the controller and output valid only
// zero operand items skip the divide and multiply
module gcd_lcm_with_overflow
    import gcdlcm_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // operand_a, operand_b, zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // gcd_value, lcm_value, overflow, zero_operand
);

    cmd_t               cmd;
    sts_t               sts;
    logic [FIELD_W-1:0] gcd_value;
    logic [FIELD_W-1:0] lcm_value;
    logic               overflow;
    logic               zero_operand;

    gcdlcm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gcdlcm_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp
    (
        .clk          (clk),
        .cmd          (cmd),
        .sts          (sts),
        .operand_a    (s_tdata[FIELD_W-1:0]),
        .operand_b    (s_tdata[2*FIELD_W-1:FIELD_W]),
        .gcd_value    (gcd_value),
        .lcm_value    (lcm_value),
        .overflow     (overflow),
        .zero_operand (zero_operand)
    );

    assign m_tdata = {zero_operand, overflow, lcm_value, gcd_value};

endmodule

// File: tb/tb.sv
// testbench for the gcd and lcm block: directed table then random operand pairs, checked by table values or a predictor
module tb
    import gcdlcm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [FIELD_W-1:0] field_t;

    typedef struct packed {
        field_t gcd;
        field_t lcm;
        logic   ovf;
        logic   zero;
    } result_t;

    typedef struct {
        field_t  a;
        field_t  b;
        bit      typed;
        result_t want;
    } dir_row_t;

    localparam int          N_DIRECTED   = 17;
    localparam int          N_RANDOM     = 750;
    localparam int          LIMIT_CYCLES = 4000000;
    localparam int          HOLD_CYCLES  = 1500;
    localparam int          DRAIN_CYCLES = 400;
    localparam logic [63:0] SIGNED_CAP   = (64'd1 << (DATA_WIDTH_DEF - 1)) - 64'd1;
    localparam field_t      MAXV         = '1;
    localparam field_t      P62          = 63'h4000_0000_0000_0000;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // operand_a, operand_b, zero pad
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // gcd_value, lcm_value, overflow, zero_operand

    result_t  expected_gcd_lcm [$];
    int       mismatches   = 0;
    int       results_seen = 0;
    logic     hold_rx      = 1'b0;
    dir_row_t dir_rows [N_DIRECTED];

    gcd_lcm_with_overflow DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic result_t gcd_lcm_of(field_t a, field_t b);
        logic [63:0] x, y, r, lhs, rhs, prod;
        result_t     res;
        x   = {1'b0, a} & SIGNED_CAP;
        y   = {1'b0, b} & SIGNED_CAP;
        lhs = x;
        rhs = y;
        res = '0;
        while (y != 64'd0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        res.gcd = x[FIELD_W-1:0];
        if (lhs == 64'd0 || rhs == 64'd0)
        begin
            res.zero = 1'b1;
        end
        else
        begin
            if (lhs > rhs)
                lhs = lhs / x;
            else
                rhs = rhs / x;
            if (lhs > SIGNED_CAP / rhs)
            begin
                res.ovf = 1'b1;
            end
            else
            begin
                prod    = lhs * rhs;
                res.lcm = prod[FIELD_W-1:0];
            end
        end
        return res;
    endfunction

    function automatic field_t rand_bits(int w);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (w < 64)
            v = v & ((64'd1 << w) - 64'd1);
        return v[FIELD_W-1:0];
    endfunction

    function automatic void random_operands(output field_t a, output field_t b);
        logic [63:0] g, t;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            // shared factor so the gcd is large and the lcm often fits
            g = rand_bits($urandom_range(1, 30));
            t = g * rand_bits($urandom_range(1, 33));
            a = t[FIELD_W-1:0];
            t = g * rand_bits($urandom_range(1, 33));
            b = t[FIELD_W-1:0];
        end
        else if (pick < 55)
        begin
            a = rand_bits($urandom_range(1, 16));
            b = rand_bits($urandom_range(1, 16));
        end
        else if (pick < 75)
        begin
            a = rand_bits(FIELD_W);
            b = rand_bits(FIELD_W);
        end
        else if (pick < 85)
        begin
            a = rand_bits($urandom_range(1, 40));
            t = a * rand_bits($urandom_range(1, 20));
            b = t[FIELD_W-1:0];
            if ($urandom_range(0, 1))
            begin
                t = a;
                a = b;
                b = t[FIELD_W-1:0];
            end
        end
        else if (pick < 92)
        begin
            a = rand_bits($urandom_range(1, FIELD_W));
            b = a;
        end
        else
        begin
            a = rand_bits($urandom_range(1, FIELD_W));
            b = rand_bits($urandom_range(1, FIELD_W));
            case ($urandom_range(0, 2))
                0: a = '0;
                1: b = '0;
                default:
                begin
                    a = '0;
                    b = '0;
                end
            endcase
        end
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        else if (pick < 95)
            return $urandom_range(1, 8);
        else
            return $urandom_range(20, 300);
    endfunction

    task automatic flag_error(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, what);
    endtask

    task automatic offer_operands(field_t a, field_t b, bit typed, result_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, b, a};
        do @(posedge clk); while (!s_tready);
        expected_gcd_lcm.push_back(typed ? want : gcd_lcm_of(a, b));
    endtask

    // result side: short and long stalls with calm stretches
    initial
    begin
        int stall_left;
        int calm_left;
        int pick;
        stall_left = 0;
        calm_left  = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (calm_left > 0)
                begin
                    calm_left--;
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15)
                        calm_left = $urandom_range(200, 2000);
                    else if (pick < 97)
                        stall_left = $urandom_range(1, 6);
                    else
                        stall_left = $urandom_range(20, 200);
                end
            end
        end
    end

    // long hold-off on the result side so the input backs up
    initial
    begin
        wait (results_seen >= 30);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.gcd  = m_tdata[FIELD_W-1:0];
            got.lcm  = m_tdata[2*FIELD_W-1:FIELD_W];
            got.ovf  = m_tdata[2*FIELD_W];
            got.zero = m_tdata[2*FIELD_W+1];
            results_seen++;
            if (expected_gcd_lcm.size() == 0)
            begin
                flag_error($sformatf("unexpected item gcd=%0d lcm=%0d ovf=%0b zero=%0b",
                                     got.gcd, got.lcm, got.ovf, got.zero));
            end
            else
            begin
                want = expected_gcd_lcm.pop_front();
                if (got.gcd !== want.gcd || got.lcm !== want.lcm ||
                    got.ovf !== want.ovf || got.zero !== want.zero)
                    flag_error($sformatf(
                        "mismatch exp gcd=%0d lcm=%0d ovf=%0b zero=%0b got gcd=%0d lcm=%0d ovf=%0b zero=%0b",
                        want.gcd, want.lcm, want.ovf, want.zero,
                        got.gcd, got.lcm, got.ovf, got.zero));
            end
        end
    end

    initial
    begin
        field_t a;
        field_t b;
        dir_rows = '{
            '{63'd0, 63'd0, 1'b1, '{63'd0, 63'd0, 1'b0, 1'b1}},
            '{63'd0, MAXV,  1'b1, '{MAXV,  63'd0, 1'b0, 1'b1}},
            '{MAXV,  63'd0, 1'b1, '{MAXV,  63'd0, 1'b0, 1'b1}},
            '{63'd0, 63'd1, 1'b1, '{63'd1, 63'd0, 1'b0, 1'b1}},
            '{MAXV,  MAXV,  1'b1, '{MAXV,  MAXV,  1'b0, 1'b0}},
            '{63'd1, 63'd1, 1'b1, '{63'd1, 63'd1, 1'b0, 1'b0}},
            '{63'd1, MAXV,  1'b1, '{63'd1, MAXV,  1'b0, 1'b0}},
            '{MAXV,  63'd1, 1'b1, '{63'd1, MAXV,  1'b0, 1'b0}},
            '{MAXV,  MAXV - 63'd1, 1'b1, '{63'd1, 63'd0, 1'b1, 1'b0}},
            '{P62,   P62,   1'b1, '{P62,   P62,   1'b0, 1'b0}},
            '{P62,   63'd2, 1'b1, '{63'd2, P62,   1'b0, 1'b0}},
            '{P62,   63'd3, 1'b1, '{63'd1, 63'd0, 1'b1, 1'b0}},
            '{63'd12, 63'd18, 1'b0, '0},
            '{63'd18, 63'd12, 1'b0, '0},
            '{63'd6,  63'd6,  1'b0, '0},
            '{63'h1_8000_0000, 63'h2_8000_0000, 1'b0, '0},
            '{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0}
        };
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++)
            offer_operands(dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            random_operands(a, b);
            offer_operands(a, b, 1'b0, '0);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (expected_gcd_lcm.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_gcd_lcm.size() != 0)
            flag_error($sformatf("%0d items never returned", expected_gcd_lcm.size()));
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
